/* src/load_cell_adc_reader_macros.svh */
// Assertion macros used by the load cell reader checker.
`ifndef LOAD_CELL_ADC_READER_MACROS_SVH
`define LOAD_CELL_ADC_READER_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define LCAR_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define LCAR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/lcar_pkg.sv */
// Types and constants shared by the load cell reader modules.
`default_nettype none

package lcar_pkg;

    // Stream widths.
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 64;
    localparam int RESULT_W  = 60;

    // Converter word handling.
    localparam int         WORD_W    = 24;
    localparam logic [4:0] DATA_BITS = 5'd24;
    localparam logic [23:0] TOP_FLIP = 24'h80_0000;

    // Command codes carried in the kind field.
    localparam logic [1:0] KIND_TICK   = 2'd0;
    localparam logic [1:0] KIND_TARE   = 2'd1;
    localparam logic [1:0] KIND_WEIGHT = 2'd2;

    // Read sequencer phases.
    typedef enum logic [4:0] {
        PH_IDLE    = 5'b00001,
        PH_SETTLE  = 5'b00010,
        PH_WAITLOW = 5'b00100,
        PH_HIGH    = 5'b01000,
        PH_LOW     = 5'b10000
    } lcar_phase_t;

    // Sequencer stage result handed to the scaling stage.
    typedef struct packed {
        logic        valid;
        logic        sck;
        logic        busy;
        logic [23:0] raw_word;
        logic        raw_valid;
        logic        weight_go;
        logic [23:0] diff;
    } lcar_stage_t;

endpackage

`default_nettype wire

/* src/load_cell_adc_reader.sv */
// Top level of the load cell converter reader with its register port.
//
// Channel  Direction  Content
// s_*      in         one time tick: kind command, sampled converter data line
// m_*      out        one result per tick: clock level, busy, word, weight
// APB      in/out     half_period_ticks at 0x0, scale_reciprocal at 0x4
//
// One tick is accepted every cycle while s_tready is high; its result passes
// through the input register, sequencer, multiplier and output register.
// The single 24 x 24 multiplier in the scaling stage sets the stage timing.
// Reset puts the sequencer in idle with tare and weight zero and the
// registers at their default values.
// When m_tready stays low one further result is held in the skid entry,
// then s_tready falls until the output register is taken.
`default_nettype none

module load_cell_adc_reader
    import lcar_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // Tick stream.
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,  // [0] dout, [7:1] zero
    input  wire logic [1:0]           s_tuser,  // [1:0] kind
    // Result stream.
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // [0] sck, [1] busy_res, [25:2] raw_word, [26] raw_valid,
    // [58:27] weight_fixed, [59] weight_valid, [63:60] zero
    output logic [M_TDATA_W-1:0]      m_tdata,
    // Register port.
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [2:0]           paddr,
    input  wire logic [31:0]          pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);

    localparam logic REG_HALF_PERIOD = 1'b0;
    localparam logic REG_SCALE       = 1'b1;

    logic [15:0]         half_period_reg;
    logic [23:0]         scale_reg;
    logic                cfg_write;
    logic                pipe_en;
    logic                in_valid_reg;
    logic [1:0]          kind_reg;
    logic                dout_reg;
    lcar_stage_t         stage;
    logic                res_valid;
    logic [RESULT_W-1:0] res_data;
    logic [RESULT_W-1:0] out_data;

    // Register writes complete in the access phase.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_period_reg <= 16'd5;
            scale_reg       <= 24'd157533;
        end
        else if (cfg_write)
        begin
            case (paddr[2])
                REG_HALF_PERIOD: half_period_reg <= pwdata[15:0];
                REG_SCALE:       scale_reg       <= pwdata[23:0];
                default:         half_period_reg <= half_period_reg;
            endcase
        end
    end

    // Register read-back.
    always_comb
    begin
        case (paddr[2])
            REG_HALF_PERIOD: prdata = {16'd0, half_period_reg};
            REG_SCALE:       prdata = {8'd0, scale_reg};
            default:         prdata = 32'd0;
        endcase
    end

    // The whole pipeline moves when the output buffer has room.
    assign s_tready = pipe_en;

    // Input register for one tick transaction.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (pipe_en)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            kind_reg <= s_tuser;
            dout_reg <= s_tdata[0];
        end
    end

    lcar_ctrl u_ctrl (
        .clk               (clk),
        .rst_n             (rst_n),
        .en                (pipe_en),
        .in_valid          (in_valid_reg),
        .kind              (kind_reg),
        .dout              (dout_reg),
        .half_period_ticks (half_period_reg),
        .stage             (stage)
    );

    lcar_scale u_scale (
        .clk              (clk),
        .rst_n            (rst_n),
        .en               (pipe_en),
        .stage            (stage),
        .scale_reciprocal (scale_reg),
        .out_valid        (res_valid),
        .out_data         (res_data)
    );

    lcar_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (res_valid),
        .in_data   (res_data),
        .in_ready  (pipe_en),
        .out_valid (m_tvalid),
        .out_data  (out_data),
        .out_ready (m_tready)
    );

    assign m_tdata = {{(M_TDATA_W - RESULT_W){1'b0}}, out_data};

endmodule

`default_nettype wire

/* src/lcar_ctrl.sv */
// Read sequencer: clock generation, bit capture and tare handling per tick.
`default_nettype none

module lcar_ctrl
    import lcar_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        en,
    input  wire logic        in_valid,
    input  wire logic [1:0]  kind,
    input  wire logic        dout,
    input  wire logic [15:0] half_period_ticks,
    output lcar_stage_t      stage
);

    lcar_phase_t phase_reg, phase_next;
    logic        read_is_weight_reg, read_is_weight_next;
    logic [4:0]  bit_count_reg, bit_count_next;
    logic [23:0] shift_word_reg, shift_word_next;
    logic [15:0] tick_count_reg, tick_count_next;
    logic [23:0] tare_word_reg, tare_word_next;
    logic        clock_level_reg, clock_level_next;
    logic [23:0] last_word_reg, last_word_next;
    lcar_stage_t stage_reg, stage_next;

    logic [15:0] half;
    logic [15:0] tick_inc;
    logic        tick_done;
    logic [15:0] tick_after;
    logic [23:0] word_done;
    logic        raw_valid;
    logic        weight_go;

    // Phase timer: a zero half period counts as one tick.
    assign half       = (half_period_ticks == 16'd0) ? 16'd1 : half_period_ticks;
    assign tick_inc   = tick_count_reg + 16'd1;
    assign tick_done  = (tick_inc >= half) || (tick_inc == 16'd0);
    assign tick_after = tick_done ? 16'd0 : tick_inc;
    assign word_done  = shift_word_reg ^ TOP_FLIP;

    // Next state of the sequencer for one tick.
    always_comb
    begin
        phase_next          = phase_reg;
        read_is_weight_next = read_is_weight_reg;
        bit_count_next      = bit_count_reg;
        shift_word_next     = shift_word_reg;
        tick_count_next     = tick_count_reg;
        tare_word_next      = tare_word_reg;
        clock_level_next    = clock_level_reg;
        last_word_next      = last_word_reg;
        raw_valid           = 1'b0;
        weight_go           = 1'b0;

        case (phase_reg)
            PH_IDLE:
            begin
                if (kind == KIND_TARE || kind == KIND_WEIGHT)
                begin
                    read_is_weight_next = (kind == KIND_WEIGHT);
                    tick_count_next     = 16'd0;
                    bit_count_next      = 5'd0;
                    shift_word_next     = 24'd0;
                    clock_level_next    = 1'b0;
                    phase_next          = PH_SETTLE;
                end
            end
            PH_SETTLE:
            begin
                tick_count_next = tick_after;
                if (tick_done)
                begin
                    phase_next = PH_WAITLOW;
                end
            end
            PH_WAITLOW:
            begin
                if (!dout)
                begin
                    clock_level_next = 1'b1;
                    tick_count_next  = 16'd0;
                    phase_next       = PH_HIGH;
                end
            end
            PH_HIGH:
            begin
                tick_count_next = tick_after;
                if (tick_done)
                begin
                    clock_level_next = 1'b0;
                    if (bit_count_reg < DATA_BITS)
                    begin
                        phase_next = PH_LOW;
                    end
                    else
                    begin
                        // Gain pulse finished: the word is complete.
                        last_word_next = word_done;
                        raw_valid      = 1'b1;
                        if (read_is_weight_reg)
                        begin
                            weight_go = (word_done > tare_word_reg);
                        end
                        else
                        begin
                            tare_word_next = word_done;
                        end
                        bit_count_next = 5'd0;
                        phase_next     = PH_IDLE;
                    end
                end
            end
            PH_LOW:
            begin
                tick_count_next = tick_after;
                // Sample the data line on the first tick of the low phase.
                if (tick_count_reg == 16'd0)
                begin
                    shift_word_next = {shift_word_reg[WORD_W-2:0], dout};
                    bit_count_next  = bit_count_reg + 5'd1;
                end
                if (tick_done)
                begin
                    clock_level_next = 1'b1;
                    phase_next       = PH_HIGH;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    // Stage result for the scaling stage.
    always_comb
    begin
        stage_next.valid     = in_valid;
        stage_next.sck       = clock_level_next;
        stage_next.busy      = (phase_next != PH_IDLE);
        stage_next.raw_word  = last_word_next;
        stage_next.raw_valid = raw_valid;
        stage_next.weight_go = weight_go;
        stage_next.diff      = word_done - tare_word_reg;
    end

    // State registers advance only on a real tick.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_IDLE;
            read_is_weight_reg <= 1'b0;
            bit_count_reg      <= 5'd0;
            shift_word_reg     <= 24'd0;
            tick_count_reg     <= 16'd0;
            tare_word_reg      <= 24'd0;
            clock_level_reg    <= 1'b0;
            last_word_reg      <= 24'd0;
        end
        else if (en && in_valid)
        begin
            phase_reg          <= phase_next;
            read_is_weight_reg <= read_is_weight_next;
            bit_count_reg      <= bit_count_next;
            shift_word_reg     <= shift_word_next;
            tick_count_reg     <= tick_count_next;
            tare_word_reg      <= tare_word_next;
            clock_level_reg    <= clock_level_next;
            last_word_reg      <= last_word_next;
        end
    end

    // Result register toward the scaling stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= '0;
        end
        else if (en)
        begin
            stage_reg <= stage_next;
        end
    end

    assign stage = stage_reg;

endmodule

`default_nettype wire

/* src/lcar_scale.sv */
// Scaling stage: net weight multiply and result word assembly.
`default_nettype none

module lcar_scale
    import lcar_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                en,
    input  lcar_stage_t              stage,
    input  wire logic [23:0]         scale_reciprocal,
    output logic                     out_valid,
    output logic [RESULT_W-1:0]      out_data
);

    logic [47:0] product;
    logic        valid_reg;
    logic        sck_reg;
    logic        busy_reg;
    logic [23:0] raw_word_reg;
    logic        raw_valid_reg;
    logic        weight_valid_reg;
    logic [31:0] weight_reg;

    // Net counts times the Q0.24 reciprocal; keep 1/256 units.
    assign product = {24'd0, stage.diff} * {24'd0, scale_reciprocal};

    // Control and held weight.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg        <= 1'b0;
            weight_valid_reg <= 1'b0;
            weight_reg       <= 32'd0;
        end
        else if (en)
        begin
            valid_reg        <= stage.valid;
            weight_valid_reg <= stage.valid && stage.weight_go;
            if (stage.valid && stage.weight_go)
            begin
                weight_reg <= product[47:16];
            end
        end
    end

    // Pass-along fields.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sck_reg       <= stage.sck;
            busy_reg      <= stage.busy;
            raw_word_reg  <= stage.raw_word;
            raw_valid_reg <= stage.raw_valid;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = {weight_valid_reg, weight_reg, raw_valid_reg, raw_word_reg,
                        busy_reg, sck_reg};

endmodule

`default_nettype wire

/* src/lcar_skid.sv */
// Output register with a skid entry so the pipeline sees a registered ready.
`default_nettype none

module lcar_skid
    import lcar_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    input  wire logic [RESULT_W-1:0] in_data,
    output logic                     in_ready,
    output logic                     out_valid,
    output logic [RESULT_W-1:0]      out_data,
    input  wire logic                out_ready
);

    logic                main_valid_reg;
    logic [RESULT_W-1:0] main_data_reg;
    logic                skid_valid_reg;
    logic [RESULT_W-1:0] skid_data_reg;
    logic                pop;
    logic                push;

    assign pop  = main_valid_reg && out_ready;
    assign push = in_valid && !skid_valid_reg;

    // Valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (main_valid_reg && !pop)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                main_valid_reg <= 1'b1;
            end
        end
        else if (pop)
        begin
            main_valid_reg <= 1'b0;
        end
    end

    // Data entries.
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                main_data_reg <= skid_data_reg;
            end
        end
        else if (push)
        begin
            if (main_valid_reg && !pop)
            begin
                skid_data_reg <= in_data;
            end
            else
            begin
                main_data_reg <= in_data;
            end
        end
    end

    assign in_ready  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_data_reg;

endmodule

`default_nettype wire

/* src/lcar_checker.sv */
// Port-level checker for the load cell reader, bound to the top level.
`default_nettype none

`include "load_cell_adc_reader_macros.svh"

module lcar_checker
    import lcar_pkg::*;
(
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 s_tready,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [M_TDATA_W-1:0] m_tdata
);

    // A stalled result transaction keeps its payload.
    `LCAR_ASSERT_NEXT(a_out_hold,
        m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata),
        "result changed while stalled")

    // Input back-pressure only comes from a full output buffer.
    `LCAR_ASSERT_IMPLY(a_ready_low,
        !s_tready,
        m_tvalid && !m_tready || $past(m_tvalid && !m_tready),
        "input stalled with output free")

    // A new weight only comes with a completed word at the end of a read.
    `LCAR_ASSERT_IMPLY(a_weight_raw,
        m_tvalid && m_tdata[59],
        m_tdata[26] && !m_tdata[1],
        "weight without completed word")

    // A completed word ends the read with the clock line low.
    `LCAR_ASSERT_IMPLY(a_raw_idle,
        m_tvalid && m_tdata[26],
        !m_tdata[0] && !m_tdata[1],
        "word done while clock high or busy")

    // The clock line is only driven high during a read.
    `LCAR_ASSERT_IMPLY(a_sck_busy,
        m_tvalid && m_tdata[0],
        m_tdata[1],
        "clock high while idle")

endmodule

bind load_cell_adc_reader lcar_checker u_lcar_checker (.*);

`default_nettype wire
